### src/bbs_pkg.sv
`timescale 1ns / 1ps
package bbs_pkg;

   // table geometry
   localparam int NUM_SLOTS  = 16;
   localparam int OWNER_BITS = 16;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // field widths
   localparam int REQ_W   = 104;
   localparam int RSP_W   = 72;
   localparam int CSR_W   = 33;
   localparam int SIZE_W  = 34;

   // modulo unit: one quotient bit per cycle over a 34-bit dividend
   localparam int DIV_STEPS = 34;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // result status codes
   localparam logic [2:0] ST_PLACED   = 3'd0;
   localparam logic [2:0] ST_OPENED   = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_FREED    = 3'd3;
   localparam logic [2:0] ST_FREE_ERR = 3'd4;

   // request selector
   localparam logic FUNC_ALLOC = 1'b0;

   typedef enum logic [2:0] {
      RSP_TOMB,
      RSP_BUMP,
      RSP_OPEN,
      RSP_FULL,
      RSP_FREE
   } rsp_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      logic        div_sel_fill;
      logic        save_asize;
      logic        save_off;
      logic        idx_clear;
      logic        idx_inc;
      logic        scan_note;
      logic        commit_tomb;
      logic        commit_bump;
      logic        commit_open;
      logic        commit_free;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic idx_last;
      logic match;
      logic tomb;
      logic owners_max;
      logic fits;
      logic free_found;
      logic rsp_busy;
   } stat_type;

endpackage

### src/bbs_modulo.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one dividend bit per cycle.
module bbs_modulo
   import bbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SIZE_W-1:0] dividend,
   input  logic [31:0]       divisor,
   output logic              done,
   output logic [31:0]       remainder
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [SIZE_W-1:0]    dvd_ff;
   logic [31:0]          div_ff;
   logic [31:0]          rem_ff;
   logic [32:0]          trial;
   logic [31:0]          rem_in;

   // shift in next dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[SIZE_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = 32'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[31:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[SIZE_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### src/bbs_datapath.sv
`timescale 1ns / 1ps
// Slot table, request registers, arithmetic and result register.
module bbs_datapath
   import bbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,
   input  logic             csr_valid,
   input  logic [CSR_W-1:0] csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic [2:0]       rsp_tuser
);

   // slot table
   logic                  valid_ff [NUM_SLOTS];
   logic                  tomb_ff  [NUM_SLOTS];
   logic [1:0]            kind_ff  [NUM_SLOTS];
   logic [31:0]           mask_ff  [NUM_SLOTS];
   logic [SIZE_W-1:0]     size_ff  [NUM_SLOTS];
   logic [SIZE_W-1:0]     fill_ff  [NUM_SLOTS];
   logic [OWNER_BITS-1:0] owners_ff[NUM_SLOTS];

   // request and work registers
   logic [CSR_W-1:0]  min_size_ff;
   logic [1:0]        rkind_ff;
   logic [31:0]       rsize_ff;
   logic [31:0]       ralign_ff;
   logic [31:0]       rmask_ff;
   logic [3:0]        rslot_ff;
   logic              rin_range_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [SIZE_W-1:0] asize_ff;
   logic [SIZE_W:0]   off_ff;
   logic              ff_found_ff;
   logic [SLOT_W-1:0] ff_idx_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [3:0]  rsp_slot_ff;
   logic [32:0] rsp_off_ff;
   logic [32:0] rsp_nsize_ff;

   logic [SIZE_W-1:0] div_dvd;
   logic              div_done;
   logic [31:0]       div_rem;
   logic [SIZE_W:0]   rounded;
   logic [SIZE_W+1:0] off_end;
   logic [32:0]       nsize;
   logic [32:0]       dbl_size;
   logic [SLOT_W+3:0] rel_ext;
   logic [SLOT_W+3:0] idx_ext;
   logic [SLOT_W+3:0] ff_ext;
   logic              free_ok;

   // field unpack helpers
   assign rel_ext = {{SLOT_W{1'b0}}, req_tdata[101:98]};
   assign idx_ext = {4'b0, idx_ff};
   assign ff_ext  = {4'b0, ff_idx_ff};

   // modulo operand select
   assign div_dvd = cmd.div_sel_fill ? fill_ff[idx_ff] : {2'b0, rsize_ff};

   bbs_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (ralign_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // round up to alignment
   always_comb begin
      if (div_rem != 32'd0) begin
         rounded = {1'b0, div_dvd} + {3'b0, ralign_ff} - {3'b0, div_rem};
      end else begin
         rounded = {1'b0, div_dvd};
      end
   end

   assign off_end  = {1'b0, off_ff} + {2'b0, asize_ff};
   assign dbl_size = {rsize_ff, 1'b0};
   assign nsize    = (dbl_size < min_size_ff) ? min_size_ff : dbl_size;
   assign free_ok  = rin_range_ff && valid_ff[idx_ff] && !tomb_ff[idx_ff]
                     && (owners_ff[idx_ff] != '0);

   // status to controller
   always_comb begin
      stat.div_done   = div_done;
      stat.idx_last   = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
      stat.match      = valid_ff[idx_ff] && (kind_ff[idx_ff] == rkind_ff)
                        && (mask_ff[idx_ff] == rmask_ff)
                        && (size_ff[idx_ff] >= asize_ff);
      stat.tomb       = tomb_ff[idx_ff];
      stat.owners_max = (owners_ff[idx_ff] == {OWNER_BITS{1'b1}});
      stat.fits       = (off_end <= {2'b0, size_ff[idx_ff]});
      stat.free_found = ff_found_ff;
      stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= CSR_W'(1048576);
      end else if (csr_valid) begin
         min_size_ff <= csr_data;
      end
   end

   // request capture, scan index and work registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rkind_ff     <= req_tdata[1:0];
         rsize_ff     <= req_tdata[33:2];
         ralign_ff    <= (req_tdata[65:34] == 32'd0) ? 32'd1 : req_tdata[65:34];
         rmask_ff     <= req_tdata[97:66];
         rslot_ff     <= req_tdata[101:98];
         rin_range_ff <= ({28'd0, req_tdata[101:98]} < 32'(NUM_SLOTS));
         idx_ff       <= (req_tuser == FUNC_ALLOC) ? '0 : rel_ext[SLOT_W-1:0];
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.save_asize) begin
         asize_ff <= rounded[SIZE_W-1:0];
      end
      if (cmd.save_off) begin
         off_ff <= rounded;
      end
      if (cmd.scan_note && !valid_ff[idx_ff] && !ff_found_ff) begin
         ff_idx_ff <= idx_ff;
      end
   end

   // first empty slot seen during the scan
   always_ff @(posedge clock) begin
      if (reset || cmd.load_req) begin
         ff_found_ff <= 1'b0;
      end else if (cmd.scan_note && !valid_ff[idx_ff]) begin
         ff_found_ff <= 1'b1;
      end
   end

   // slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            tomb_ff[i]  <= 1'b0;
         end
      end else begin
         if (cmd.commit_tomb) begin
            tomb_ff[idx_ff] <= 1'b0;
         end
         if (cmd.commit_open) begin
            valid_ff[ff_idx_ff] <= 1'b1;
            tomb_ff[ff_idx_ff]  <= 1'b0;
         end
         if (cmd.commit_free) begin
            // drop every tombstoned block first
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (valid_ff[i] && tomb_ff[i]) begin
                  valid_ff[i] <= 1'b0;
                  tomb_ff[i]  <= 1'b0;
               end
            end
            if (free_ok && (owners_ff[idx_ff] == OWNER_BITS'(1))) begin
               tomb_ff[idx_ff] <= 1'b1;
            end
         end
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (cmd.commit_tomb) begin
         fill_ff[idx_ff]   <= asize_ff;
         owners_ff[idx_ff] <= OWNER_BITS'(1);
      end
      if (cmd.commit_bump) begin
         fill_ff[idx_ff]   <= off_end[SIZE_W-1:0];
         owners_ff[idx_ff] <= owners_ff[idx_ff] + 1'b1;
      end
      if (cmd.commit_open) begin
         kind_ff[ff_idx_ff]   <= rkind_ff;
         mask_ff[ff_idx_ff]   <= rmask_ff;
         size_ff[ff_idx_ff]   <= {1'b0, nsize};
         fill_ff[ff_idx_ff]   <= asize_ff;
         owners_ff[ff_idx_ff] <= OWNER_BITS'(1);
      end
      if (cmd.commit_free && free_ok) begin
         owners_ff[idx_ff] <= owners_ff[idx_ff] - 1'b1;
      end
   end

   // result register handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result contents
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_off_ff   <= '0;
         rsp_nsize_ff <= '0;
         rsp_slot_ff  <= idx_ext[3:0];
         unique case (cmd.rsp_sel)
            RSP_TOMB: begin
               rsp_status_ff <= ST_PLACED;
            end
            RSP_BUMP: begin
               rsp_status_ff <= ST_PLACED;
               rsp_off_ff    <= off_ff[32:0];
            end
            RSP_OPEN: begin
               rsp_status_ff <= ST_OPENED;
               rsp_slot_ff   <= ff_ext[3:0];
               rsp_nsize_ff  <= nsize;
            end
            RSP_FULL: begin
               rsp_status_ff <= ST_FULL;
               rsp_slot_ff   <= 4'd0;
            end
            RSP_FREE: begin
               rsp_status_ff <= free_ok ? ST_FREED : ST_FREE_ERR;
               rsp_slot_ff   <= rslot_ff;
            end
            default: begin
               rsp_status_ff <= ST_FULL;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b0, rsp_nsize_ff, rsp_off_ff, rsp_slot_ff};

endmodule

### src/bbs_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: alignment, slot scan, commit and result.
module bbs_ctrl
   import bbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_tuser,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ASZ,
      S_ASZ_WAIT,
      S_SCAN,
      S_OFF_WAIT,
      S_CHECK,
      S_TOMB,
      S_BUMP,
      S_END,
      S_FREE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = RSP_FULL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_tuser == FUNC_ALLOC) ? S_ASZ : S_FREE;
            end
         end
         S_ASZ: begin
            cmd.div_start = 1'b1;
            state_in      = S_ASZ_WAIT;
         end
         S_ASZ_WAIT: begin
            if (stat.div_done) begin
               cmd.save_asize = 1'b1;
               cmd.idx_clear  = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_note = 1'b1;
            priority if (stat.match && stat.tomb) begin
               state_in = S_TOMB;
            end else if (stat.match && !stat.owners_max) begin
               cmd.div_start    = 1'b1;
               cmd.div_sel_fill = 1'b1;
               state_in         = S_OFF_WAIT;
            end else if (stat.idx_last) begin
               state_in = S_END;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_OFF_WAIT: begin
            cmd.div_sel_fill = 1'b1;
            if (stat.div_done) begin
               cmd.save_off = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (stat.fits) begin
               state_in = S_BUMP;
            end else if (stat.idx_last) begin
               state_in = S_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_TOMB: begin
            cmd.rsp_sel = RSP_TOMB;
            if (!stat.rsp_busy) begin
               cmd.commit_tomb = 1'b1;
               cmd.rsp_load    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_BUMP: begin
            cmd.rsp_sel = RSP_BUMP;
            if (!stat.rsp_busy) begin
               cmd.commit_bump = 1'b1;
               cmd.rsp_load    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_END: begin
            cmd.rsp_sel = stat.free_found ? RSP_OPEN : RSP_FULL;
            if (!stat.rsp_busy) begin
               cmd.commit_open = stat.free_found;
               cmd.rsp_load    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FREE: begin
            cmd.rsp_sel = RSP_FREE;
            if (!stat.rsp_busy) begin
               cmd.commit_free = 1'b1;
               cmd.rsp_load    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

### src/block_bump_suballocator_core.sv
`timescale 1ns / 1ps
// Bump-pointer block suballocator over a 16-slot block table. One request is
// worked at a time. A release commits and loads its result in the release
// state once the result register is free, and the next request is then taken
// in idle. An allocation first rounds its size up to the alignment in the
// bit-serial remainder unit, then scans the slots one per cycle. Each block
// that matches, is not tombstoned and is below the owner limit costs another
// remainder pass to align its fill offset. A waiting result delays only the
// final commit step. The user must write min_block_size on the csr channel
// only while no request is in flight; the block itself does not enforce this.
module block_bump_suballocator_core
   import bbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // alloc_kind[1:0], request_size[33:2], alignment[65:34],
   // memory_type_mask[97:66], release_slot[101:98]
   input  logic [REQ_W-1:0] req_tdata,
   // func[0]
   input  logic             req_tuser,
   input  logic             req_tvalid,
   output logic             req_tready,
   // block_slot[3:0], region_offset[36:4], new_block_size[69:37]
   output logic [RSP_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   bbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bbs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### src/bbs_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel.
module bbs_checker
   import bbs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [2:0]       rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   // status is a defined code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_FREE_ERR)
      else $error("undefined status");

   // block size only on a newly opened block
   a_nsize: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OPENED |-> rsp_tdata[69:37] == 33'd0)
      else $error("new block size without open");

   // no offset on release, full table or newly opened block
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FREED || rsp_tuser == ST_FREE_ERR
         || rsp_tuser == ST_FULL || rsp_tuser == ST_OPENED)
         |-> rsp_tdata[36:4] == 33'd0)
      else $error("offset on non-placing result");

   // nothing offered right after a reset cycle
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind block_bump_suballocator_core bbs_checker u_bbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/tb_block_bump_suballocator_core.sv
`timescale 1ns / 1ps
module tb_block_bump_suballocator_core;
   import bbs_pkg::*;

   localparam logic [1:0] SEND_STALL_HEAVY = 2'd0;
   localparam logic [1:0] RECV_STALL_HEAVY = 2'd1;
   localparam logic [1:0] NO_STALL         = 2'd2;
   localparam int         OWNER_MAX        = (1 << OWNER_BITS) - 1;

   // one decoded allocator response
   typedef struct {
      logic [2:0]  status;
      logic [3:0]  block_slot;
      logic [32:0] region_offset;
      logic [32:0] new_block_size;
   } alloc_rsp_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [32:0] got,
                                  input logic [32:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // predictor of the block table plus queue of pending responses
   class suballoc_scoreboard;
      logic [32:0]   min_size;
      logic          valid_q [NUM_SLOTS];
      logic [1:0]    kind_q  [NUM_SLOTS];
      logic [31:0]   tmask_q [NUM_SLOTS];
      logic [33:0]   size_q  [NUM_SLOTS];
      logic [33:0]   fill_q  [NUM_SLOTS];
      int unsigned   owners_q[NUM_SLOTS];
      logic          tomb_q  [NUM_SLOTS];
      alloc_rsp_type pending_rsp[$];

      function new();
         min_size = 33'd1048576;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_q[i] = 0; tomb_q[i] = 0; kind_q[i] = 0; tmask_q[i] = 0;
            size_q[i] = 0; fill_q[i] = 0; owners_q[i] = 0;
         end
      endfunction

      function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
         logic [63:0] r;
         r = v % a;
         return (r != 0) ? v + (a - r) : v;
      endfunction

      function automatic alloc_rsp_type do_alloc(logic [1:0] kind, logic [31:0] sz,
                                                 logic [31:0] al, logic [31:0] tm);
         alloc_rsp_type r;
         logic [63:0]   align, asize, off, nsize;
         r = '{3'd0, 4'd0, 33'd0, 33'd0};
         align = (al == 0) ? 64'd1 : {32'd0, al};
         asize = round_up({32'd0, sz}, align);
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!valid_q[i] || kind_q[i] != kind || tmask_q[i] != tm) continue;
            if ({30'd0, size_q[i]} < asize) continue;
            if (tomb_q[i]) begin
               fill_q[i] = asize[33:0]; tomb_q[i] = 0; owners_q[i] = 1;
               r.status = ST_PLACED; r.block_slot = 4'(i);
               return r;
            end
            if (owners_q[i] >= OWNER_MAX) continue;
            off = round_up({30'd0, fill_q[i]}, align);
            if (off + asize > {30'd0, size_q[i]}) continue;
            fill_q[i] = off[33:0] + asize[33:0];
            owners_q[i]++;
            r.status = ST_PLACED; r.block_slot = 4'(i); r.region_offset = off[32:0];
            return r;
         end
         nsize = {32'd0, sz} * 2;
         if (nsize < {31'd0, min_size}) nsize = {31'd0, min_size};
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (valid_q[i]) continue;
            valid_q[i] = 1; kind_q[i] = kind; tmask_q[i] = tm; size_q[i] = nsize[33:0];
            fill_q[i] = asize[33:0]; owners_q[i] = 1; tomb_q[i] = 0;
            r.status = ST_OPENED; r.block_slot = 4'(i); r.new_block_size = nsize[32:0];
            return r;
         end
         r.status = ST_FULL;
         return r;
      endfunction

      function automatic alloc_rsp_type do_release(logic [3:0] slot);
         alloc_rsp_type r;
         r = '{ST_FREE_ERR, slot, 33'd0, 33'd0};
         for (int i = 0; i < NUM_SLOTS; i++)
            if (valid_q[i] && tomb_q[i]) begin
               valid_q[i] = 0; tomb_q[i] = 0;
            end
         if (!valid_q[slot] || owners_q[slot] == 0) return r;
         if (owners_q[slot] == 1) tomb_q[slot] = 1;
         owners_q[slot]--;
         r.status = ST_FREED;
         return r;
      endfunction

      function void note_request(logic func, logic [REQ_W-1:0] d);
         if (func == FUNC_ALLOC)
            pending_rsp = {pending_rsp, do_alloc(d[1:0], d[33:2], d[65:34], d[97:66])};
         else
            pending_rsp = {pending_rsp, do_release(d[101:98])};
      endfunction

      task check_response(logic [2:0] st, logic [RSP_W-1:0] d);
         alloc_rsp_type w;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", {30'd0, st}, 33'd0);
            return;
         end
         w = pending_rsp.pop_front();
         if (st != w.status) report_mismatch("status", {30'd0, st}, {30'd0, w.status});
         if (d[3:0] != w.block_slot)
            report_mismatch("block_slot", {29'd0, d[3:0]}, {29'd0, w.block_slot});
         if (d[36:4] != w.region_offset)
            report_mismatch("region_offset", d[36:4], w.region_offset);
         if (d[69:37] != w.new_block_size)
            report_mismatch("new_block_size", d[69:37], w.new_block_size);
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 0;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic             csr_valid = 0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   suballoc_scoreboard sb = new();
   logic [1:0] stall_mode = SEND_STALL_HEAVY;

   block_bump_suballocator_core i_dut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // response side with random back-pressure, except in NO_STALL mode
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
      case (stall_mode)
         SEND_STALL_HEAVY: rsp_tready <= ($urandom_range(99) >= 55);
         RECV_STALL_HEAVY: rsp_tready <= ($urandom_range(99) >= 30);
         default:          rsp_tready <= 1'b1;
      endcase
   end

   // valid stays up after a transfer until the next call drives or drops it
   task automatic send_request(input logic func, input logic [1:0] kind,
                               input logic [31:0] sz, input logic [31:0] al,
                               input logic [31:0] tm, input logic [3:0] slot);
      int gap_pct;
      gap_pct = (stall_mode == SEND_STALL_HEAVY) ? 30 :
                (stall_mode == RECV_STALL_HEAVY) ? 55 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, slot, tm, al, sz, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, {2'b00, slot, tm, al, sz, kind});
   endtask

   // waits for the block to drain, then writes min_block_size
   task automatic write_min_size(input logic [32:0] v);
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.min_size = v;
      csr_valid <= 0;
   endtask

   // mostly small sizes and alignments over a few kinds/masks, some noise
   task automatic random_request();
      logic [31:0] sz, al, tm;
      logic [1:0]  kind;
      kind = 2'($urandom_range(1));
      tm   = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1);
      case ($urandom_range(9))
         0:       sz = $urandom();
         1, 2:    sz = $urandom_range(65536);
         default: sz = $urandom_range(300);
      endcase
      case ($urandom_range(9))
         0:       al = $urandom();
         1:       al = 0;
         default: al = $urandom_range(1, 24);
      endcase
      if ($urandom_range(99) < 35)
         send_request(~FUNC_ALLOC, 2'd0, $urandom(), $urandom(), $urandom(),
                      4'($urandom_range(15)));
      else
         send_request(FUNC_ALLOC, kind, sz, al, tm, 4'($urandom_range(15)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, zero alignment, tiny block, table fill, releases
      send_request(FUNC_ALLOC, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_request(FUNC_ALLOC, 2'd0, 32'd0, 32'd0, 32'd0, 4'd0);
      send_request(FUNC_ALLOC, 2'd0, 32'd100, 32'd0, 32'd0, 4'd0);
      send_request(FUNC_ALLOC, 2'd0, 32'd7, 32'd3, 32'd0, 4'd0);
      send_request(FUNC_ALLOC, 2'd0, 32'd5, 32'h8000_0001, 32'd0, 4'd0);
      send_request(~FUNC_ALLOC, 2'd0, 32'd0, 32'd0, 32'd0, 4'd15);
      send_request(~FUNC_ALLOC, 2'd0, 32'd0, 32'd0, 32'd0, 4'd0);
      write_min_size(33'd1);
      send_request(FUNC_ALLOC, 2'd1, 32'd10, 32'd16, 32'h5555_AAAA, 4'd0);
      send_request(FUNC_ALLOC, 2'd1, 32'd30, 32'd4, 32'h5555_AAAA, 4'd0);
      for (int i = 0; i < 14; i++)
         send_request(FUNC_ALLOC, 2'd2, 32'd1000 + i, 32'd1, i, 4'd0);
      send_request(~FUNC_ALLOC, 2'd0, 32'd0, 32'd0, 32'd0, 4'd2);
      send_request(FUNC_ALLOC, 2'd0, 32'd1, 32'd1, 32'd77, 4'd0);
      write_min_size(33'h1_FFFF_FFFF);

      // random phases, each under a different stall pattern and threshold
      for (int p = 0; p < 3; p++) begin
         stall_mode = p[1:0];
         for (int n = 0; n < 600; n++) begin
            random_request();
            if (n % 150 == 149) begin
               req_tvalid <= 1'b0;
               while (sb.pending_rsp.size() != 0) @(posedge clock);
               repeat (20) @(posedge clock);
               // thin out the table: release every slot once
               for (int s = 0; s < NUM_SLOTS; s++)
                  send_request(~FUNC_ALLOC, 2'd0, 32'd0, 32'd0, 32'd0, 4'(s));
            end
         end
         write_min_size((p == 0) ? 33'd64 : (p == 1) ? 33'd1048576 : $urandom_range(1, 4096));
      end

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
src/bbs_pkg.sv
src/bbs_modulo.sv
src/bbs_datapath.sv
src/bbs_ctrl.sv
src/block_bump_suballocator_core.sv
src/bbs_checker.sv
test/tb_block_bump_suballocator_core.sv
